FILE: rtl/hpbp_pkg.sv
// Shared types and constants for the HTTP request byte parser.
// No dependencies; imported by the core, the number parser, the checker and the bench.
`timescale 1ns / 1ps

package hpbp_pkg;

  typedef enum logic [3:0] {
    PH_METHOD   = 4'd0,
    PH_PATH     = 4'd1,
    PH_VERSION  = 4'd2,
    PH_FIRST_LF = 4'd3,
    PH_NAME     = 4'd4,
    PH_VALUE    = 4'd5,
    PH_HDR_LF   = 4'd6,
    PH_LAST_LF  = 4'd7,
    PH_BODY     = 4'd8,
    PH_END      = 4'd9
  } hpbp_phase_t;

  typedef enum logic [1:0] {
    NP_WS     = 2'd0,
    NP_SIGN   = 2'd1,
    NP_DIGITS = 2'd2,
    NP_STOP   = 2'd3
  } hpbp_num_phase_t;

  typedef enum logic [2:0] {
    CLS_METHOD  = 3'd0,
    CLS_PATH    = 3'd1,
    CLS_VERSION = 3'd2,
    CLS_NAME    = 3'd3,
    CLS_VALUE   = 3'd4,
    CLS_DELIM   = 3'd5,
    CLS_BODY    = 3'd6,
    CLS_IGNORED = 3'd7
  } hpbp_cls_t;

  // Control from the header sequencer to the length number parser.
  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] data;
  } hpbp_num_ctl_t;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] KEY_LEN = 4'd14;

  // "Content-Length", one character per match position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h43;  // C
      4'd1:    ch = 8'h6F;  // o
      4'd2:    ch = 8'h6E;  // n
      4'd3:    ch = 8'h74;  // t
      4'd4:    ch = 8'h65;  // e
      4'd5:    ch = 8'h6E;  // n
      4'd6:    ch = 8'h74;  // t
      4'd7:    ch = 8'h2D;  // -
      4'd8:    ch = 8'h4C;  // L
      4'd9:    ch = 8'h65;  // e
      4'd10:   ch = 8'h6E;  // n
      4'd11:   ch = 8'h67;  // g
      4'd12:   ch = 8'h74;  // t
      4'd13:   ch = 8'h68;  // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/hpbp_ifs.sv
// Valid/ready channel interfaces for the HTTP request byte parser.
// Depends on nothing; the result channel width follows LENGTH_BITS.
`timescale 1ns / 1ps

interface hpbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hpbp_out_if #(
  parameter int LENGTH_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             byte_out;
  logic [2:0]             byte_class;
  logic                   header_line_done;
  logic                   headers_done;
  logic                   has_length;
  logic [LENGTH_BITS-1:0] length_value;
  logic                   length_error;
  logic [LENGTH_BITS-1:0] body_left;
  logic                   request_end;

  modport source (
    output valid, output byte_out, output byte_class, output header_line_done,
    output headers_done, output has_length, output length_value,
    output length_error, output body_left, output request_end,
    input ready
  );
  modport sink (
    input valid, input byte_out, input byte_class, input header_line_done,
    input headers_done, input has_length, input length_value,
    input length_error, input body_left, input request_end,
    output ready
  );
endinterface

FILE: rtl/http_request_byte_parser_core.sv
// HTTP request byte parser: classifies request bytes, tracks Content-Length
// and counts the body. Depends on hpbp_pkg, hpbp_ifs and hpbp_num.
//
// Usage:
//   in_ch carries one raw request byte per transfer (valid/ready). out_ch
//   returns one result per input byte: the byte itself, its class, line and
//   header-block end flags, the current Content-Length state, the body bytes
//   still expected and an end-of-request flag.
// Datapath:
//   A byte is held in the input register and evaluated on its way into the
//   output register, which presents its result. One byte per clock is
//   sustained while out_ch is ready; per-byte work is a small state update
//   plus one shift-add.
// Stalls:
//   While out_ch is held, the input register still takes one more byte;
//   in_ch.ready drops only when both registers are full.
// Reset:
//   rst_n (synchronous) returns the parser to the method field of a new
//   request with no length seen and empties both registers. After a request
//   completes, all further bytes are tagged ignored until reset.
`timescale 1ns / 1ps

module http_request_byte_parser_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  hpbp_in_if.sink   in_ch,
  hpbp_out_if.source out_ch
);
  import hpbp_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic [7:0] c;

  // parser state
  hpbp_phase_t            phase_r, phase_nxt;
  logic                   name_empty_r, name_empty_nxt;
  logic [3:0]             key_pos_r, key_pos_nxt;
  logic                   key_mis_r, key_mis_nxt;
  logic                   len_seen_r, len_seen_nxt;
  logic [LENGTH_BITS-1:0] len_stored_r, len_stored_nxt;
  logic                   len_bad_r, len_bad_nxt;
  logic [LENGTH_BITS-1:0] body_r, body_nxt;

  // per-byte decisions
  hpbp_cls_t              cls;
  logic                   line_done;
  logic                   hdr_done;
  logic                   req_end;
  logic                   name_byte;
  logic                   hdr_start;
  logic                   commit;
  logic [LENGTH_BITS-1:0] body_load;
  logic [LENGTH_BITS-1:0] body_dec;

  hpbp_num_ctl_t          num_ctl;
  logic [LENGTH_BITS-1:0] num_value;
  logic                   num_bad;
  logic                   num_neg;
  logic                   num_seen;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  hpbp_cls_t  out_cls_r;
  logic       out_line_r;
  logic       out_hdr_r;
  logic       out_end_r;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign c           = in_byte_r;

  assign body_load = len_seen_r ? len_stored_r : '0;
  assign body_dec  = (body_r != '0) ? body_r - LENGTH_BITS'(1) : body_r;

  // byte class and strobes
  always_comb begin
    cls       = CLS_IGNORED;
    line_done = 1'b0;
    hdr_done  = 1'b0;
    req_end   = 1'b0;
    name_byte = 1'b0;
    hdr_start = 1'b0;
    commit    = 1'b0;
    unique case (phase_r)
      PH_METHOD:  cls = (c == CH_SP) ? CLS_DELIM : CLS_METHOD;
      PH_PATH:    cls = (c == CH_SP) ? CLS_DELIM : CLS_PATH;
      PH_VERSION: cls = (c == CH_CR) ? CLS_DELIM : CLS_VERSION;
      PH_FIRST_LF: begin
        if (c == CH_LF) begin
          cls       = CLS_DELIM;
          hdr_start = 1'b1;
        end
      end
      PH_NAME: begin
        if ((name_empty_r && c == CH_CR) || c == CH_COLON) begin
          cls = CLS_DELIM;
        end else begin
          cls       = CLS_NAME;
          name_byte = 1'b1;
        end
      end
      PH_VALUE:   cls = (c == CH_CR) ? CLS_DELIM : CLS_VALUE;
      PH_HDR_LF: begin
        if (c == CH_LF) begin
          cls       = CLS_DELIM;
          line_done = 1'b1;
          commit    = 1'b1;
          hdr_start = 1'b1;
        end
      end
      PH_LAST_LF: begin
        if (c == CH_LF) begin
          cls      = CLS_DELIM;
          hdr_done = 1'b1;
          req_end  = (body_load == '0);
        end
      end
      PH_BODY: begin
        cls     = CLS_BODY;
        req_end = (body_dec == '0);
      end
      default: cls = CLS_IGNORED;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    name_empty_nxt = name_empty_r;
    key_pos_nxt    = key_pos_r;
    key_mis_nxt    = key_mis_r;
    len_seen_nxt   = len_seen_r;
    len_stored_nxt = len_stored_r;
    len_bad_nxt    = len_bad_r;
    body_nxt       = body_r;
    unique case (phase_r)
      PH_METHOD:   if (c == CH_SP) phase_nxt = PH_PATH;
      PH_PATH:     if (c == CH_SP) phase_nxt = PH_VERSION;
      PH_VERSION:  if (c == CH_CR) phase_nxt = PH_FIRST_LF;
      PH_FIRST_LF: if (c == CH_LF) phase_nxt = PH_NAME;
      PH_NAME: begin
        if (name_empty_r && c == CH_CR) begin
          phase_nxt = PH_LAST_LF;
        end else if (c == CH_COLON) begin
          phase_nxt = PH_VALUE;
        end else begin
          name_empty_nxt = 1'b0;
        end
      end
      PH_VALUE:    if (c == CH_CR) phase_nxt = PH_HDR_LF;
      PH_HDR_LF:   if (c == CH_LF) phase_nxt = PH_NAME;
      PH_LAST_LF: begin
        if (c == CH_LF) begin
          body_nxt  = body_load;
          phase_nxt = (body_load == '0) ? PH_END : PH_BODY;
        end
      end
      PH_BODY: begin
        body_nxt = body_dec;
        if (body_dec == '0) phase_nxt = PH_END;
      end
      default: phase_nxt = PH_END;
    endcase

    // exact, case-sensitive match against the key while the name arrives
    if (name_byte) begin
      if (key_mis_r || key_pos_r >= KEY_LEN || key_char(key_pos_r) != c) begin
        key_mis_nxt = 1'b1;
      end else begin
        key_pos_nxt = key_pos_r + 4'd1;
      end
    end

    // last matching header wins
    if (commit && !key_mis_r && key_pos_r == KEY_LEN) begin
      len_seen_nxt = 1'b1;
      if (!num_seen || (num_neg && (num_value != '0 || num_bad))) begin
        len_stored_nxt = '0;
        len_bad_nxt    = 1'b1;
      end else begin
        len_stored_nxt = num_value;
        len_bad_nxt    = num_bad;
      end
    end

    if (hdr_start) begin
      name_empty_nxt = 1'b1;
      key_pos_nxt    = '0;
      key_mis_nxt    = 1'b0;
    end
  end

  assign num_ctl.clear = advance && hdr_start;
  assign num_ctl.feed  = advance && phase_r == PH_VALUE && c != CH_CR;
  assign num_ctl.data  = c;

  hpbp_num #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_num (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (num_ctl),
    .value     (num_value),
    .bad       (num_bad),
    .neg       (num_neg),
    .seen_digit(num_seen)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_METHOD;
      name_empty_r <= 1'b1;
      key_pos_r    <= '0;
      key_mis_r    <= 1'b0;
      len_seen_r   <= 1'b0;
      len_stored_r <= '0;
      len_bad_r    <= 1'b0;
      body_r       <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        phase_r      <= phase_nxt;
        name_empty_r <= name_empty_nxt;
        key_pos_r    <= key_pos_nxt;
        key_mis_r    <= key_mis_nxt;
        len_seen_r   <= len_seen_nxt;
        len_stored_r <= len_stored_nxt;
        len_bad_r    <= len_bad_nxt;
        body_r       <= body_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
    end
    if (advance) begin
      out_byte_r <= c;
      out_cls_r  <= cls;
      out_line_r <= line_done;
      out_hdr_r  <= hdr_done;
      out_end_r  <= req_end;
    end
  end

  // length and body state only change together with the output register
  assign out_ch.valid            = out_valid_r;
  assign out_ch.byte_out         = out_byte_r;
  assign out_ch.byte_class       = out_cls_r;
  assign out_ch.header_line_done = out_line_r;
  assign out_ch.headers_done     = out_hdr_r;
  assign out_ch.has_length       = len_seen_r;
  assign out_ch.length_value     = len_stored_r;
  assign out_ch.length_error     = len_bad_r;
  assign out_ch.body_left        = body_r;
  assign out_ch.request_end      = out_end_r;

endmodule

FILE: rtl/hpbp_num.sv
// Decimal parser for a header value: whitespace, sign, digits, saturation.
// Depends on hpbp_pkg.
`timescale 1ns / 1ps

module hpbp_num #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hpbp_pkg::hpbp_num_ctl_t ctl,
  output logic [LENGTH_BITS-1:0] value,
  output logic                   bad,
  output logic                   neg,
  output logic                   seen_digit
);
  import hpbp_pkg::*;

  localparam int PW = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  hpbp_num_phase_t        np_r, np_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic                   bad_r, bad_nxt;
  logic                   neg_r, neg_nxt;
  logic                   seen_r, seen_nxt;

  logic          is_ws;
  logic          is_dig;
  logic [PW-1:0] acc_ext;
  logic [PW-1:0] prod;
  logic          ovf;

  assign is_ws  = (ctl.data == CH_SP) || (ctl.data == CH_TAB) || (ctl.data == CH_LF) ||
                  (ctl.data == CH_VT) || (ctl.data == CH_FF);
  assign is_dig = (ctl.data >= CH_ZERO) && (ctl.data <= CH_NINE);

  // acc*10 + d; anything above the low LENGTH_BITS is an overflow
  assign acc_ext = {4'b0000, acc_r};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + PW'(ctl.data - CH_ZERO);
  assign ovf     = |prod[PW-1:LENGTH_BITS];

  always_comb begin
    np_nxt   = np_r;
    acc_nxt  = acc_r;
    bad_nxt  = bad_r;
    neg_nxt  = neg_r;
    seen_nxt = seen_r;
    if (ctl.clear) begin
      np_nxt   = NP_WS;
      acc_nxt  = '0;
      bad_nxt  = 1'b0;
      neg_nxt  = 1'b0;
      seen_nxt = 1'b0;
    end else if (ctl.feed && np_r != NP_STOP) begin
      if (np_r == NP_WS && is_ws) begin
        np_nxt = NP_WS;
      end else if (np_r == NP_WS && (ctl.data == CH_PLUS || ctl.data == CH_MINUS)) begin
        neg_nxt = (ctl.data == CH_MINUS);
        np_nxt  = NP_SIGN;
      end else if (!is_dig) begin
        np_nxt = NP_STOP;
      end else begin
        np_nxt   = NP_DIGITS;
        seen_nxt = 1'b1;
        if (ovf) begin
          acc_nxt = LEN_MAX;
          bad_nxt = 1'b1;
        end else begin
          acc_nxt = prod[LENGTH_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r   <= NP_WS;
      acc_r  <= '0;
      bad_r  <= 1'b0;
      neg_r  <= 1'b0;
      seen_r <= 1'b0;
    end else begin
      np_r   <= np_nxt;
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
      neg_r  <= neg_nxt;
      seen_r <= seen_nxt;
    end
  end

  assign value      = acc_r;
  assign bad        = bad_r;
  assign neg        = neg_r;
  assign seen_digit = seen_r;

endmodule

FILE: rtl/hpbp_checker.sv
// Port-level checks for the HTTP request byte parser, bound to the top level.
// Depends on hpbp_pkg and http_request_byte_parser_core.
`timescale 1ns / 1ps

module hpbp_checker #(
  parameter int LENGTH_BITS = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [7:0]             out_byte,
  input logic [2:0]             out_class,
  input logic                   out_line_done,
  input logic                   out_headers_done,
  input logic [LENGTH_BITS-1:0] out_body_left,
  input logic                   out_request_end
);
  import hpbp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_end_no_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_end |-> out_body_left == '0)
    else $error("request end with body bytes left");

  a_lf_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_line_done || out_headers_done) |->
      out_byte == CH_LF && out_class == CLS_DELIM && !(out_line_done && out_headers_done))
    else $error("line or header-block end on a byte that is not a line feed");

endmodule

bind http_request_byte_parser_core hpbp_checker #(
  .LENGTH_BITS(LENGTH_BITS)
) u_hpbp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_byte        (out_ch.byte_out),
  .out_class       (out_ch.byte_class),
  .out_line_done   (out_ch.header_line_done),
  .out_headers_done(out_ch.headers_done),
  .out_body_left   (out_ch.body_left),
  .out_request_end (out_ch.request_end)
);

FILE: tb/sv/tb.sv
// Self-checking bench for http_request_byte_parser_core: streams one long request
// through the parser, predicts every per-byte result and compares in order.
// Depends on hpbp_pkg, hpbp_ifs and the parser RTL.
`timescale 1ns / 1ps

module tb;
  import hpbp_pkg::*;

  localparam int LEN_W = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HEADER_BYTES = 880;
  localparam string LEN_KEY = "Content-Length";

  typedef struct packed {
    logic [7:0]       data;
    hpbp_cls_t        cls;
    logic             line_done;
    logic             hdrs_done;
    logic             has_len;
    logic [LEN_W-1:0] len_val;
    logic             len_err;
    logic [LEN_W-1:0] remaining;
    logic             req_end;
  } byte_result_t;

  logic clk = 1'b0;
  logic rst_n;

  hpbp_in_if                        in_ch ();
  hpbp_out_if #(.LENGTH_BITS(LEN_W)) out_ch ();

  http_request_byte_parser_core #(.LENGTH_BITS(LEN_W)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  logic [7:0]   request_bytes[$];
  byte_result_t expected_results[$];
  int           bytes_sent;
  int           third;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           mismatch_count;
  int           quiet_cycles;

  // parser state mirror
  hpbp_phase_t      req_phase;
  hpbp_num_phase_t  num_phase;
  logic             name_blank;
  logic [3:0]       key_pos;
  logic             key_miss;
  logic [LEN_W-1:0] num_val;
  logic             num_ovf;
  logic             num_neg;
  logic             num_digits;
  logic             len_seen;
  logic [LEN_W-1:0] len_val;
  logic             len_err;
  logic [LEN_W-1:0] body_rem;

  task automatic new_header();
    name_blank = 1'b1;
    key_pos    = '0;
    key_miss   = 1'b0;
    num_phase  = NP_WS;
    num_val    = '0;
    num_ovf    = 1'b0;
    num_neg    = 1'b0;
    num_digits = 1'b0;
  endtask

  task automatic reset_parser();
    req_phase = PH_METHOD;
    new_header();
    len_seen = 1'b0;
    len_val  = '0;
    len_err  = 1'b0;
    body_rem = '0;
  endtask

  task automatic key_step(input logic [7:0] c);
    if (key_miss || key_pos >= KEY_LEN) begin
      key_miss = 1'b1;
    end else if (LEN_KEY[key_pos] == c) begin
      key_pos++;
    end else begin
      key_miss = 1'b1;
    end
  endtask

  // strtol-like digit accumulation with saturation
  task automatic number_step(input logic [7:0] c);
    logic             ws;
    logic             dig;
    logic [LEN_W-1:0] d;
    logic [LEN_W-1:0] mx;
    ws  = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF);
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d   = LEN_W'(c - CH_ZERO);
    mx  = '1;
    if (num_phase == NP_STOP) return;
    if (num_phase == NP_WS && ws) return;
    if (num_phase == NP_WS && (c == CH_PLUS || c == CH_MINUS)) begin
      num_neg   = (c == CH_MINUS);
      num_phase = NP_SIGN;
      return;
    end
    if (!dig) begin
      num_phase = NP_STOP;
      return;
    end
    num_phase  = NP_DIGITS;
    num_digits = 1'b1;
    if (num_val > (mx - d) / 10) begin
      num_val = mx;
      num_ovf = 1'b1;
    end else begin
      num_val = num_val * 10 + d;
    end
  endtask

  task automatic commit_length();
    if (key_miss || key_pos != KEY_LEN) return;
    len_seen = 1'b1;
    if (!num_digits || (num_neg && (num_val != 0 || num_ovf))) begin
      len_val = '0;
      len_err = 1'b1;
    end else begin
      len_val = num_val;
      len_err = num_ovf;
    end
  endtask

  task automatic parse_byte(input logic [7:0] c);
    byte_result_t r;
    r      = '0;
    r.data = c;
    r.cls  = CLS_IGNORED;
    case (req_phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          r.cls = CLS_DELIM;
          req_phase = PH_PATH;
        end else r.cls = CLS_METHOD;
      end
      PH_PATH: begin
        if (c == CH_SP) begin
          r.cls = CLS_DELIM;
          req_phase = PH_VERSION;
        end else r.cls = CLS_PATH;
      end
      PH_VERSION: begin
        if (c == CH_CR) begin
          r.cls = CLS_DELIM;
          req_phase = PH_FIRST_LF;
        end else r.cls = CLS_VERSION;
      end
      PH_FIRST_LF: begin
        if (c == CH_LF) begin
          r.cls = CLS_DELIM;
          req_phase = PH_NAME;
          new_header();
        end
      end
      PH_NAME: begin
        if (name_blank && c == CH_CR) begin
          r.cls = CLS_DELIM;
          req_phase = PH_LAST_LF;
        end else if (c == CH_COLON) begin
          r.cls = CLS_DELIM;
          req_phase = PH_VALUE;
        end else begin
          r.cls = CLS_NAME;
          name_blank = 1'b0;
          key_step(c);
        end
      end
      PH_VALUE: begin
        if (c == CH_CR) begin
          r.cls = CLS_DELIM;
          req_phase = PH_HDR_LF;
        end else begin
          r.cls = CLS_VALUE;
          number_step(c);
        end
      end
      PH_HDR_LF: begin
        if (c == CH_LF) begin
          r.cls = CLS_DELIM;
          r.line_done = 1'b1;
          commit_length();
          new_header();
          req_phase = PH_NAME;
        end
      end
      PH_LAST_LF: begin
        if (c == CH_LF) begin
          r.cls = CLS_DELIM;
          r.hdrs_done = 1'b1;
          body_rem = len_seen ? len_val : '0;
          if (body_rem == 0) begin
            r.req_end = 1'b1;
            req_phase = PH_END;
          end else req_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        r.cls = CLS_BODY;
        if (body_rem != 0) body_rem--;
        if (body_rem == 0) begin
          r.req_end = 1'b1;
          req_phase = PH_END;
        end
      end
      default: req_phase = PH_END;
    endcase
    r.has_len   = len_seen;
    r.len_val   = len_val;
    r.len_err   = len_err;
    r.remaining = body_rem;
    expected_results.push_back(r);
  endtask

  // ---------------- stimulus construction ----------------

  function automatic logic [7:0] rand_byte_but(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == b);
    return v;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endtask

  // mode 0 truncated, 1 extra byte, 2 case flip, 3 replaced byte, other exact
  task automatic push_key_like(input int mode);
    int         cut;
    int         pos;
    logic [7:0] ch;
    cut = (mode == 0) ? $urandom_range(1, 13) : 14;
    pos = $urandom_range(0, 13);
    for (int i = 0; i < cut; i++) begin
      ch = LEN_KEY[i];
      if (mode == 2 && i == pos) ch = ch ^ 8'h20;
      if (mode == 3 && i == pos) ch = rand_byte_but(CH_COLON, CH_CR);
      request_bytes.push_back(ch);
    end
    if (mode == 1) request_bytes.push_back(rand_byte_but(CH_COLON, CH_COLON));
  endtask

  task automatic push_length_value();
    int               n;
    longint unsigned  v;
    for (int i = $urandom_range(0, 2); i > 0; i--) begin
      case ($urandom_range(0, 4))
        0:       request_bytes.push_back(CH_SP);
        1:       request_bytes.push_back(CH_TAB);
        2:       request_bytes.push_back(CH_LF);
        3:       request_bytes.push_back(CH_VT);
        default: request_bytes.push_back(CH_FF);
      endcase
    end
    case ($urandom_range(0, 5))
      0:       request_bytes.push_back(CH_PLUS);
      1:       request_bytes.push_back(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: ;  // no digits at all
      1: for (int i = $urandom_range(1, 3); i > 0; i--) request_bytes.push_back(CH_ZERO);
      2: push_text($sformatf("%0d", $urandom_range(0, 99)));
      3: push_text($sformatf("%0d", $urandom % 100000));
      4: begin
        v = 64'hFFFF_FFFF - $urandom_range(0, 20);
        push_text($sformatf("%0d", v));
      end
      5: begin
        v = 64'h1_0000_0000 + $urandom_range(0, 20);
        push_text($sformatf("%0d", v));
      end
      6: begin
        n = $urandom_range(11, 20);
        for (int i = 0; i < n; i++) request_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      default: push_text($sformatf("%0d", $urandom));
    endcase
    if ($urandom_range(0, 3) == 0)
      for (int i = $urandom_range(1, 3); i > 0; i--)
        request_bytes.push_back(rand_byte_but(CH_CR, CH_CR));
  endtask

  task automatic push_junk_value();
    for (int i = $urandom_range(0, 8); i > 0; i--)
      request_bytes.push_back(rand_byte_but(CH_CR, CH_CR));
  endtask

  task automatic push_header_line();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: push_key_like(4);
      4, 5:       push_key_like($urandom_range(0, 3));
      6: begin
        request_bytes.push_back(rand_byte_but(CH_COLON, CH_CR));
        for (int i = $urandom_range(0, 7); i > 0; i--)
          request_bytes.push_back(rand_byte_but(CH_COLON, CH_COLON));
      end
      7: ;  // empty name
      8: begin
        // carriage return inside a non-empty name
        request_bytes.push_back(rand_byte_but(CH_COLON, CH_CR));
        request_bytes.push_back(CH_CR);
        for (int i = $urandom_range(0, 3); i > 0; i--)
          request_bytes.push_back(rand_byte_but(CH_COLON, CH_COLON));
      end
      default: push_key_like(4);
    endcase
    request_bytes.push_back(CH_COLON);
    if (kind <= 5) push_length_value();
    else push_junk_value();
    request_bytes.push_back(CH_CR);
    if ($urandom_range(0, 5) == 0)
      for (int i = $urandom_range(1, 3); i > 0; i--)
        request_bytes.push_back(rand_byte_but(CH_LF, CH_LF));
    request_bytes.push_back(CH_LF);
  endtask

  task automatic build_request();
    int body_len;
    // request line with byte extremes and a stray byte before its line feed
    request_bytes.push_back(8'h00);
    request_bytes.push_back(8'hFF);
    push_text("G /");
    request_bytes.push_back(8'h80);
    push_text(" H/1");
    request_bytes.push_back(CH_CR);
    push_text("Q");
    request_bytes.push_back(CH_LF);
    push_text("a");
    request_bytes.push_back(CH_CR);
    push_text("b:1");
    request_bytes.push_back(CH_CR);
    push_text("x");
    request_bytes.push_back(CH_LF);
    push_text(":7");
    request_bytes.push_back(CH_CR);
    request_bytes.push_back(CH_LF);

    while (request_bytes.size() < HEADER_BYTES) push_header_line();

    // last length wins: keep the body short
    body_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 60);
    push_text($sformatf("Content-Length: %0d", body_len));
    request_bytes.push_back(CH_CR);
    request_bytes.push_back(CH_LF);
    request_bytes.push_back(CH_CR);
    if ($urandom_range(0, 1) == 1) request_bytes.push_back(rand_byte_but(CH_LF, CH_LF));
    request_bytes.push_back(CH_LF);
    for (int i = 0; i < body_len; i++) request_bytes.push_back(8'($urandom));
    for (int i = 0; i < 20; i++) request_bytes.push_back(8'($urandom));
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin : driver_proc
    logic hold;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= '0;
      reset_parser();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.in_byte);
        bytes_sent++;
      end
      if (bytes_sent < third) begin
        send_idle_pct = 17;
        recv_idle_pct = 59;
      end else if (bytes_sent < 2 * third) begin
        send_idle_pct = 59;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        // let the parser drain completely at each idling change-over
        hold = (bytes_sent == third || bytes_sent == 2 * third) &&
               (expected_results.size() != 0);
        if (request_bytes.size() != 0 && !hold &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= request_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor_proc
    byte_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing pending: byte_out %0h", out_ch.byte_out);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("byte_out", want.data, out_ch.byte_out);
          check_field("byte_class", want.cls, out_ch.byte_class);
          check_field("header_line_done", want.line_done, out_ch.header_line_done);
          check_field("headers_done", want.hdrs_done, out_ch.headers_done);
          check_field("has_length", want.has_len, out_ch.has_length);
          check_field("length_value", want.len_val, out_ch.length_value);
          check_field("length_error", want.len_err, out_ch.length_error);
          check_field("body_left", want.remaining, out_ch.body_left);
          check_field("request_end", want.req_end, out_ch.request_end);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    bytes_sent     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 17;
    recv_idle_pct  = 59;
    build_request();
    third = request_bytes.size() / 3;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (request_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
